@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files of the compensation block.
// No dependencies; included by the top level, which carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define PTHC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// condition that must never be seen outside reset
`define PTHC_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ hw/rtl/pthc_pkg.sv @@
// Shared types and constants of the pressure/temperature/humidity compensation block.
// No dependencies; used by pthc_sdiv and the top level.
package pthc_pkg;

  localparam int DIV_W = 64;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_CAL_T  = 3'd0;
  localparam logic [2:0] CFG_CAL_PL = 3'd1;
  localparam logic [2:0] CFG_CAL_PH = 3'd2;
  localparam logic [2:0] CFG_CAL_PH_HUM = 3'd3;
  localparam logic [2:0] CFG_CAL_H  = 3'd4;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_W       = 64;

  localparam logic signed [32:0] TF_OFS_P   = 33'sd128000;
  localparam logic signed [31:0] TF_OFS_H   = 32'sd76800;
  localparam logic [20:0]        P_FULL     = 21'd1048576;
  localparam logic [11:0]        P_SCALE    = 12'd3125;
  localparam logic signed [31:0] H_RND_A    = 32'sd16384;
  localparam logic signed [31:0] H_OFS_C    = 32'sd32768;
  localparam logic signed [31:0] H_OFS_D    = 32'sd2097152;
  localparam logic signed [31:0] H_RND_E    = 32'sd8192;
  localparam logic signed [31:0] H_CLAMP    = 32'sd419430400;
  localparam logic [16:0]        H_OUT_MAX  = 17'd102400;
  localparam logic signed [63:0] P_ONE_47   = 64'sh0000_8000_0000_0000;

  // items carried alongside the divider
  typedef struct packed {
    logic               zero;   // divisor was zero
    logic signed [17:0] temp;   // finished temperature
    logic signed [31:0] hx2;    // humidity intermediate
  } side_t;

endpackage

@@ hw/rtl/pthc_sdiv.sv @@
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit per stage.
// Depends on pthc_pkg (DIV_W, side_t). Returns the quotient magnitude and its sign.
module pthc_sdiv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ce,
  input  logic                  in_valid,
  input  logic signed [63:0]    in_num,
  input  logic signed [63:0]    in_den,
  input  pthc_pkg::side_t       in_side,
  output logic                  out_valid,
  output logic [63:0]           out_quot,
  output logic                  out_neg,
  output pthc_pkg::side_t       out_side
);

  localparam int W = pthc_pkg::DIV_W;

  logic [W:0]      vld_r;
  logic [W-1:0]    dvd_r  [0:W];
  logic [W-1:0]    rem_r  [0:W-1];
  logic [W-1:0]    dsr_r  [0:W-1];
  logic            neg_r  [0:W];
  pthc_pkg::side_t side_r [0:W];

  logic [W-1:0]    dvd_nxt [1:W];
  logic [W-1:0]    rem_nxt [1:W];
  logic [W-1:0]    num_abs, den_abs;

  assign num_abs = in_num[W-1] ? (~in_num + 1'b1) : in_num;
  assign den_abs = in_den[W-1] ? (~in_den + 1'b1) : in_den;

  // restoring step: shift in the next dividend bit, subtract when it fits
  always_comb begin
    logic [W:0] trial;
    logic       ge;
    for (int k = 1; k <= W; k++) begin
      trial = {rem_r[k-1], dvd_r[k-1][W-1]};
      ge    = trial >= {1'b0, dsr_r[k-1]};
      dvd_nxt[k] = {dvd_r[k-1][W-2:0], ge};
      rem_nxt[k] = ge ? trial[W-1:0] - dsr_r[k-1] : trial[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dvd_r[0]  <= num_abs;
      rem_r[0]  <= '0;
      dsr_r[0]  <= den_abs;
      neg_r[0]  <= in_num[W-1] ^ in_den[W-1];
      side_r[0] <= in_side;
      for (int k = 1; k <= W; k++) begin
        dvd_r[k]  <= dvd_nxt[k];
        neg_r[k]  <= neg_r[k-1];
        side_r[k] <= side_r[k-1];
      end
      for (int k = 1; k < W; k++) begin
        rem_r[k] <= rem_nxt[k];
        dsr_r[k] <= dsr_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[W];
  assign out_quot  = dvd_r[W];
  assign out_neg   = neg_r[W];
  assign out_side  = side_r[W];

endmodule

@@ hw/rtl/pressure_temp_humidity_compensation.sv @@
// Integer compensation of one raw pressure/temperature/humidity sample per transfer. The block
// takes one input transfer every cycle unless stalled and returns results in order through ten
// stages of temperature, pressure and humidity arithmetic, a 65-stage signed divider (a load
// stage, then one quotient bit per stage) that sets the depth, and five finishing stages ending
// in the output register. All stages advance together; a stalled output holds the pipeline.
// Calibration is written through cfg_we/cfg_index/cfg_wdata while no sample is in flight; the
// user must ensure it, not the block. Depends on pthc_pkg, pthc_sdiv and assert_macros.svh.
`include "assert_macros.svh"

module pressure_temp_humidity_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40]
  input  logic [pthc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // temperature_centi[17:0], pressure_pa[41:18], humidity_q10[58:42], zeros above
  output logic [pthc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [pthc_pkg::CFG_W-1:0]       cfg_wdata
);

  // ---------------- calibration registers ----------------
  logic [47:0] cal_t_r, cal_ph_hum_r;
  logic [63:0] cal_pl_r, cal_ph_r;
  logic [31:0] cal_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t_r      <= '0;
      cal_pl_r     <= '0;
      cal_ph_r     <= '0;
      cal_ph_hum_r <= '0;
      cal_h_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pthc_pkg::CFG_CAL_T:      cal_t_r      <= cfg_wdata[47:0];
        pthc_pkg::CFG_CAL_PL:     cal_pl_r     <= cfg_wdata;
        pthc_pkg::CFG_CAL_PH:     cal_ph_r     <= cfg_wdata;
        pthc_pkg::CFG_CAL_PH_HUM: cal_ph_hum_r <= cfg_wdata[47:0];
        pthc_pkg::CFG_CAL_H:      cal_h_r      <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic [7:0]         h1, h3;
  logic signed [31:0] t2x, t3x, h2x, h4x, h5x, h6x;
  logic signed [15:0] p2, p3, p5, p6, p8, p9;
  logic signed [63:0] p4x, p7x;

  assign t1  = cal_t_r[15:0];
  assign t2x = {{16{cal_t_r[31]}}, cal_t_r[31:16]};
  assign t3x = {{16{cal_t_r[47]}}, cal_t_r[47:32]};
  assign p1  = cal_pl_r[15:0];
  assign p2  = cal_pl_r[31:16];
  assign p3  = cal_pl_r[47:32];
  assign p4x = {{48{cal_pl_r[63]}}, cal_pl_r[63:48]};
  assign p5  = cal_ph_r[15:0];
  assign p6  = cal_ph_r[31:16];
  assign p7x = {{48{cal_ph_r[47]}}, cal_ph_r[47:32]};
  assign p8  = cal_ph_r[63:48];
  assign p9  = cal_ph_hum_r[15:0];
  assign h1  = cal_ph_hum_r[23:16];
  assign h2x = {{16{cal_ph_hum_r[39]}}, cal_ph_hum_r[39:24]};
  assign h3  = cal_ph_hum_r[47:40];
  assign h4x = {{20{cal_h_r[11]}}, cal_h_r[11:0]};
  assign h5x = {{20{cal_h_r[23]}}, cal_h_r[23:12]};
  assign h6x = {{24{cal_h_r[31]}}, cal_h_r[31:24]};

  // ---------------- pipeline control ----------------
  logic       ce;
  logic [9:0] pv_r;     // valid of stages 1..10
  logic [4:0] qv_r;     // valid of finishing stages, [4] is the output register
  logic       dv;

  assign ce         = !qv_r[4] || out_tready;
  assign in_tready  = ce;
  assign out_tvalid = qv_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      qv_r <= '0;
    end else if (ce) begin
      pv_r <= {pv_r[8:0], in_tvalid};
      qv_r <= {qv_r[3:0], dv};
    end
  end

  // ---------------- stage combinational logic ----------------
  logic [19:0]        adc_t;
  logic [31:0]        ta_nxt, tb_nxt;
  logic signed [31:0] tc_sum, tc_shr;
  logic signed [17:0] temp_nxt;
  logic signed [65:0] v1sq_full;
  logic signed [48:0] v1p5_full, v1p2_full;
  logic signed [79:0] v2a_full, v1b_full, p8p_full, p9aa_full;
  logic signed [31:0] ha_sum;
  logic signed [80:0] v1d_full;
  logic [20:0]        pdif;
  logic signed [31:0] dd_sum, e_sum, e_shr;
  logic signed [63:0] den_shr;
  logic [75:0]        num_full;

  // stage registers
  logic signed [31:0] s1_ta_r, s1_tb_r;
  logic [19:0]        s1_adcp_r;
  logic [15:0]        s1_adch_r;
  logic signed [31:0] s2_m1_r, s2_bb_r;
  logic [19:0]        s2_adcp_r;
  logic [15:0]        s2_adch_r;
  logic signed [31:0] s3_a_r, s3_bt_r;
  logic [19:0]        s3_adcp_r;
  logic [15:0]        s3_adch_r;
  logic signed [31:0] s4_tf_r;
  logic [19:0]        s4_adcp_r;
  logic [15:0]        s4_adch_r;
  logic signed [17:0] s5_temp_r;
  logic signed [32:0] s5_v1_r;
  logic signed [31:0] s5_x_r;
  logic [19:0]        s5_adcp_r;
  logic [15:0]        s5_adch_r;
  logic signed [63:0] s6_v1sq_r, s6_v1p5_r, s6_v1p2_r;
  logic signed [31:0] s6_hm_r, s6_xh6_r, s6_xh3_r;
  logic signed [17:0] s6_temp_r;
  logic [19:0]        s6_adcp_r;
  logic [15:0]        s6_adch_r;
  logic signed [63:0] s7_v2a_r, s7_v1b_r, s7_p5t_r, s7_p2t_r;
  logic signed [31:0] s7_ha_r, s7_hb_r, s7_hc_r;
  logic signed [17:0] s7_temp_r;
  logic [19:0]        s7_adcp_r;
  logic signed [63:0] s8_v2_r, s8_v1c_r;
  logic signed [31:0] s8_bc_r, s8_ha_r;
  logic signed [17:0] s8_temp_r;
  logic [19:0]        s8_adcp_r;
  logic signed [63:0] s9_v1d_r, s9_pre_r;
  logic signed [31:0] s9_dh2_r, s9_ha_r;
  logic signed [17:0] s9_temp_r;
  logic signed [30:0] s10_den_r;
  logic [63:0]        s10_num_r;
  logic signed [31:0] s10_x2_r;
  logic signed [17:0] s10_temp_r;

  assign adc_t  = in_tdata[39:20];
  assign ta_nxt = {15'd0, adc_t[19:3]} - {15'd0, t1, 1'b0};
  assign tb_nxt = {16'd0, adc_t[19:4]} - {16'd0, t1};

  assign tc_sum = s4_tf_r * 32'sd5 + 32'sd128;
  assign tc_shr = tc_sum >>> 8;
  always_comb begin
    if (tc_shr > 32'sd131071) begin
      temp_nxt = 18'sd131071;
    end else if (tc_shr < -32'sd131072) begin
      temp_nxt = -18'sd131072;
    end else begin
      temp_nxt = tc_shr[17:0];
    end
  end

  assign v1sq_full = s5_v1_r * s5_v1_r;
  assign v1p5_full = s5_v1_r * p5;
  assign v1p2_full = s5_v1_r * p2;
  assign v2a_full  = s6_v1sq_r * p6;
  assign v1b_full  = s6_v1sq_r * p3;
  assign ha_sum    = $signed({2'd0, s6_adch_r, 14'd0}) - (h4x <<< 20) - s6_hm_r
                     + pthc_pkg::H_RND_A;
  assign v1d_full  = (s8_v1c_r + pthc_pkg::P_ONE_47) * $signed({1'b0, p1});
  assign pdif      = pthc_pkg::P_FULL - {1'b0, s8_adcp_r};
  assign dd_sum    = (s8_bc_r >>> 10) + pthc_pkg::H_OFS_D;
  assign den_shr   = s9_v1d_r >>> 33;
  assign num_full  = $unsigned(s9_pre_r) * pthc_pkg::P_SCALE;
  assign e_sum     = s9_dh2_r + pthc_pkg::H_RND_E;
  assign e_shr     = e_sum >>> 14;

  always_ff @(posedge clk) begin
    if (ce) begin
      // temperature
      s1_ta_r   <= ta_nxt;
      s1_tb_r   <= tb_nxt;
      s1_adcp_r <= in_tdata[19:0];
      s1_adch_r <= in_tdata[55:40];
      s2_m1_r   <= s1_ta_r * t2x;
      s2_bb_r   <= s1_tb_r * s1_tb_r;
      s2_adcp_r <= s1_adcp_r;
      s2_adch_r <= s1_adch_r;
      s3_a_r    <= s2_m1_r >>> 11;
      s3_bt_r   <= (s2_bb_r >>> 12) * t3x;
      s3_adcp_r <= s2_adcp_r;
      s3_adch_r <= s2_adch_r;
      s4_tf_r   <= s3_a_r + (s3_bt_r >>> 14);
      s4_adcp_r <= s3_adcp_r;
      s4_adch_r <= s3_adch_r;
      s5_temp_r <= temp_nxt;
      s5_v1_r   <= {s4_tf_r[31], s4_tf_r} - pthc_pkg::TF_OFS_P;
      s5_x_r    <= s4_tf_r - pthc_pkg::TF_OFS_H;
      s5_adcp_r <= s4_adcp_r;
      s5_adch_r <= s4_adch_r;
      // pressure and humidity products
      s6_v1sq_r <= v1sq_full[63:0];
      s6_v1p5_r <= {{15{v1p5_full[48]}}, v1p5_full};
      s6_v1p2_r <= {{15{v1p2_full[48]}}, v1p2_full};
      s6_hm_r   <= s5_x_r * h5x;
      s6_xh6_r  <= s5_x_r * h6x;
      s6_xh3_r  <= s5_x_r * $signed({24'd0, h3});
      s6_temp_r <= s5_temp_r;
      s6_adcp_r <= s5_adcp_r;
      s6_adch_r <= s5_adch_r;
      s7_v2a_r  <= v2a_full[63:0];
      s7_v1b_r  <= v1b_full[63:0];
      s7_p5t_r  <= s6_v1p5_r <<< 17;
      s7_p2t_r  <= s6_v1p2_r <<< 12;
      s7_ha_r   <= ha_sum >>> 15;
      s7_hb_r   <= s6_xh6_r >>> 10;
      s7_hc_r   <= (s6_xh3_r >>> 11) + pthc_pkg::H_OFS_C;
      s7_temp_r <= s6_temp_r;
      s7_adcp_r <= s6_adcp_r;
      s8_v2_r   <= s7_v2a_r + s7_p5t_r + (p4x <<< 35);
      s8_v1c_r  <= (s7_v1b_r >>> 8) + s7_p2t_r;
      s8_bc_r   <= s7_hb_r * s7_hc_r;
      s8_ha_r   <= s7_ha_r;
      s8_temp_r <= s7_temp_r;
      s8_adcp_r <= s7_adcp_r;
      s9_v1d_r  <= v1d_full[63:0];
      s9_pre_r  <= $signed({12'd0, pdif, 31'd0}) - s8_v2_r;
      s9_dh2_r  <= dd_sum * h2x;
      s9_ha_r   <= s8_ha_r;
      s9_temp_r <= s8_temp_r;
      s10_den_r <= den_shr[30:0];
      s10_num_r <= num_full[63:0];
      s10_x2_r  <= s9_ha_r * e_shr;
      s10_temp_r <= s9_temp_r;
    end
  end

  // ---------------- divider ----------------
  pthc_pkg::side_t div_side, dside;
  logic [63:0]     dq;
  logic            dneg;

  assign div_side.zero = (s10_den_r == '0);
  assign div_side.temp = s10_temp_r;
  assign div_side.hx2  = s10_x2_r;

  pthc_sdiv u_sdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (pv_r[9]),
    .in_num    ($signed(s10_num_r)),
    .in_den    ({{33{s10_den_r[30]}}, s10_den_r}),
    .in_side   (div_side),
    .out_valid (dv),
    .out_quot  (dq),
    .out_neg   (dneg),
    .out_side  (dside)
  );

  // ---------------- finishing stages ----------------
  logic signed [63:0] q1_p_r, q2_p_r, q3_p_r, q4_p_r;
  logic signed [31:0] q1_hsq_r, q1_x2_r, q2_a3_r, q2_x2_r;
  logic [63:0]        q2_alal_r, q3_aa_r;
  logic [31:0]        q2_alah_r;
  logic signed [63:0] q2_p8p_r, q3_p8p_r, q4_p8p_r, q4_p9aa_r;
  logic [16:0]        q3_hum_r, q4_hum_r, out_hum_r;
  logic               q1_zero_r, q2_zero_r, q3_zero_r, q4_zero_r;
  logic signed [17:0] q1_temp_r, q2_temp_r, q3_temp_r, q4_temp_r, out_temp_r;
  logic [23:0]        out_press_r;

  logic signed [63:0] p_nxt, a13;
  logic signed [31:0] a2, x3;
  logic [16:0]        hum_nxt;
  logic signed [63:0] psum, psh, pfin;

  assign p_nxt    = dside.zero ? 64'sd0 : (dneg ? $signed(~dq + 1'b1) : $signed(dq));
  assign a2       = dside.hx2 >>> 15;
  assign a13      = q1_p_r >>> 13;
  assign p8p_full = q1_p_r * p8;
  assign x3       = q2_x2_r - (q2_a3_r >>> 4);
  always_comb begin
    if (x3 < 32'sd0) begin
      hum_nxt = '0;
    end else if (x3 > pthc_pkg::H_CLAMP) begin
      hum_nxt = pthc_pkg::H_OUT_MAX;
    end else begin
      hum_nxt = x3[28:12];
    end
  end
  assign p9aa_full = $signed(q3_aa_r) * p9;
  assign psum      = q4_p_r + (q4_p9aa_r >>> 25) + (q4_p8p_r >>> 19);
  assign psh       = psum >>> 8;
  assign pfin      = psh + (p7x <<< 4);

  always_ff @(posedge clk) begin
    if (ce) begin
      q1_p_r     <= p_nxt;
      q1_hsq_r   <= a2 * a2;
      q1_x2_r    <= dside.hx2;
      q1_zero_r  <= dside.zero;
      q1_temp_r  <= dside.temp;
      // square of p>>13 modulo 2^64 from 32-bit halves
      q2_alal_r  <= a13[31:0] * a13[31:0];
      q2_alah_r  <= a13[31:0] * a13[63:32];
      q2_p8p_r   <= p8p_full[63:0];
      q2_a3_r    <= (q1_hsq_r >>> 7) * $signed({24'd0, h1});
      q2_x2_r    <= q1_x2_r;
      q2_p_r     <= q1_p_r;
      q2_zero_r  <= q1_zero_r;
      q2_temp_r  <= q1_temp_r;
      q3_aa_r    <= q2_alal_r + {q2_alah_r[30:0], 33'd0};
      q3_hum_r   <= hum_nxt;
      q3_p_r     <= q2_p_r;
      q3_p8p_r   <= q2_p8p_r;
      q3_zero_r  <= q2_zero_r;
      q3_temp_r  <= q2_temp_r;
      q4_p9aa_r  <= p9aa_full[63:0];
      q4_p_r     <= q3_p_r;
      q4_p8p_r   <= q3_p8p_r;
      q4_hum_r   <= q3_hum_r;
      q4_zero_r  <= q3_zero_r;
      q4_temp_r  <= q3_temp_r;
      out_press_r <= q4_zero_r ? 24'd0 : pfin[31:8];
      out_hum_r   <= q4_hum_r;
      out_temp_r  <= q4_temp_r;
    end
  end

  assign out_tdata = {5'd0, out_hum_r, out_press_r, out_temp_r};

  // ---------------- checks ----------------
  `PTHC_ASSERT(a_rst_clears_out, clk, rst_n, $past(!rst_n) |-> !out_tvalid,
               "output valid after reset")
  `PTHC_ASSERT(a_zero_div_press, clk, rst_n,
               (qv_r[3] && q4_zero_r && ce) |=> (out_press_r == 24'd0),
               "zero divisor gave nonzero pressure")
  `PTHC_NEVER(a_hum_range, clk, rst_n, out_tvalid && (out_hum_r > pthc_pkg::H_OUT_MAX),
              "humidity above full scale")

endmodule
